// File: rtl/core/gbn_sw_pkg.sv
// Shared types and constants for the go-back-n sender window unit.
`default_nettype none

package gbn_sw_pkg;

  // Window size default and limits of the per-job slot and count fields
  localparam int WINDOW_DEF = 8;
  localparam int SLOT_W_MAX = 6;   // enough for a window of 64
  localparam int CNT_W_MAX  = 7;   // holds a count of 64

  // Largest payload length kept for one chunk
  localparam int MAX_CHUNK = 1024;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 1'b1;
  localparam logic [15:0] TIMEOUT_RST = 16'd200;
  localparam logic [7:0]  RETRY_RST   = 8'd10;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2,
    OP_ABORT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_SEND    = 3'd0,
    ACT_REFUSED = 3'd1,
    ACT_NOTHING = 3'd2,
    ACT_DONE    = 3'd3,
    ACT_FAILED  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    HALT_RUNNING = 2'd0,
    HALT_DONE    = 2'd1,
    HALT_FAILED  = 2'd2
  } halt_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [10:0] chunk_length;
    logic [31:0] ack_number;
    logic        ack_good;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] seq_number;
    logic [10:0] send_length;
    logic        last_of_run;
  } out_item_t;

  // One job for the back end: a single result or a retransmit run
  typedef struct packed {
    logic                  is_run;
    action_t               action;
    logic [31:0]           seq;    // sequence, or first sequence of a run
    logic [10:0]           len;
    logic [SLOT_W_MAX-1:0] slot;   // slot of the first sequence of a run
    logic [CNT_W_MAX-1:0]  count;  // sequences in a run
  } job_t;

  // Slot length write from front to back
  typedef struct packed {
    logic                  en;
    logic [SLOT_W_MAX-1:0] addr;
    logic [10:0]           data;
  } slot_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/gbn_sw_queue.sv
// Small job FIFO between the classifying front end and the result back end.
`default_nettype none

module gbn_sw_queue
  import gbn_sw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      pop_job
);

  job_t               entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    count_r;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = entry_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gbn_sw_front.sv
// Front end: accepts items, keeps window/timer state and queues result jobs.
`default_nettype none

module gbn_sw_front
  import gbn_sw_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             in_item,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  output logic                      push,
  output job_t                      push_job,
  input  wire logic                 q_full,
  input  wire logic                 run_done,
  output slot_wr_t                  slot_wr
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = CW + 1;
  localparam logic [31:0] WIN32 = 32'(WINDOW);

  // Configuration
  logic [15:0] timeout_r;
  logic [7:0]  limit_r;

  // Window and timer state
  logic [31:0] base_r, base_nxt;
  logic [31:0] next_r, next_nxt;
  logic [IW-1:0] base_slot_r, base_slot_nxt;
  logic [IW-1:0] next_slot_r, next_slot_nxt;
  logic        end_r, end_nxt;
  logic        active_r, active_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [7:0]  retry_r, retry_nxt;
  halt_t       halt_r, halt_nxt;
  logic        run_pend_r, run_pend_nxt;

  logic        accept;
  logic [31:0] diff;
  logic        full;
  logic [10:0] clen_sat;
  logic [31:0] ack_off;
  logic [31:0] ack_inc;
  logic [31:0] adv;
  logic [SW-1:0] slot_sum;
  logic [15:0] el_inc;
  logic [8:0]  rounds;
  logic [CW-1:0] run_cnt;

  assign busy   = q_full || run_pend_r;
  assign accept = start && !busy;
  assign push   = accept;

  // Shared window arithmetic
  always_comb begin
    diff     = next_r - base_r;
    full     = (diff >= WIN32);
    clen_sat = (17'(in_item.chunk_length) > 17'(MAX_CHUNK)) ?
               11'(MAX_CHUNK) : in_item.chunk_length;
    ack_off  = in_item.ack_number - base_r;
    ack_inc  = in_item.ack_number + 32'd1;
    adv      = ack_inc - base_r;
    slot_sum = SW'(base_slot_r) + SW'(adv[CW-1:0]);
    el_inc   = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
    rounds   = {1'b0, retry_r} + 9'd1;
    run_cnt  = full ? CW'(WINDOW) : diff[CW-1:0];
  end

  // Item classification and next state
  always_comb begin
    base_nxt      = base_r;
    next_nxt      = next_r;
    base_slot_nxt = base_slot_r;
    next_slot_nxt = next_slot_r;
    end_nxt       = end_r;
    active_nxt    = active_r;
    elapsed_nxt   = elapsed_r;
    retry_nxt     = retry_r;
    halt_nxt      = halt_r;
    push_job      = '0;
    push_job.action = ACT_NOTHING;
    slot_wr       = '0;

    if (accept) begin
      if (halt_r != HALT_RUNNING) begin
        push_job.action = (halt_r == HALT_DONE) ? ACT_DONE : ACT_FAILED;
      end else begin
        unique case (op_t'(in_item.operation))
          OP_OFFER: begin
            if (end_r || full) begin
              push_job.action = ACT_REFUSED;
            end else begin
              slot_wr.en    = 1'b1;
              slot_wr.addr  = SLOT_W_MAX'(next_slot_r);
              slot_wr.data  = clen_sat;
              next_nxt      = next_r + 32'd1;
              next_slot_nxt = (next_slot_r == IW'(WINDOW-1)) ? '0 : next_slot_r + 1'b1;
              if (clen_sat == '0) begin
                end_nxt = 1'b1;
              end
              if (!active_r) begin
                active_nxt  = 1'b1;
                elapsed_nxt = '0;
              end
              push_job.action = ACT_SEND;
              push_job.seq    = next_r;
              push_job.len    = clen_sat;
            end
          end
          OP_ACK: begin
            if (in_item.ack_good && (ack_off < diff)) begin
              base_nxt      = ack_inc;
              base_slot_nxt = (slot_sum >= SW'(WINDOW)) ?
                              IW'(slot_sum - SW'(WINDOW)) : IW'(slot_sum);
              retry_nxt     = '0;
              elapsed_nxt   = '0;
              if (ack_inc != next_r) begin
                active_nxt = 1'b1;
              end else begin
                active_nxt = 1'b0;
                if (end_r) begin
                  halt_nxt        = HALT_DONE;
                  push_job.action = ACT_DONE;
                end
              end
            end
          end
          OP_TICK: begin
            if (active_r) begin
              elapsed_nxt = el_inc;
              if (el_inc >= timeout_r) begin
                if (rounds > {1'b0, limit_r}) begin
                  halt_nxt        = HALT_FAILED;
                  active_nxt      = 1'b0;
                  push_job.action = ACT_FAILED;
                end else begin
                  retry_nxt = rounds[7:0];
                  if (run_cnt != '0) begin
                    push_job.is_run = 1'b1;
                    push_job.action = ACT_SEND;
                    push_job.seq    = base_r;
                    push_job.slot   = SLOT_W_MAX'(base_slot_r);
                    push_job.count  = CNT_W_MAX'(run_cnt);
                    elapsed_nxt     = '0;
                  end
                end
              end
            end
          end
          OP_ABORT: begin
            halt_nxt        = HALT_FAILED;
            active_nxt      = 1'b0;
            push_job.action = ACT_FAILED;
          end
        endcase
      end
    end
  end

  // Input is held off while a retransmit run is queued or in flight
  always_comb begin
    run_pend_nxt = run_pend_r;
    if (push && push_job.is_run) begin
      run_pend_nxt = 1'b1;
    end else if (run_done) begin
      run_pend_nxt = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      limit_r     <= RETRY_RST;
      base_r      <= '0;
      next_r      <= '0;
      base_slot_r <= '0;
      next_slot_r <= '0;
      end_r       <= 1'b0;
      active_r    <= 1'b0;
      elapsed_r   <= '0;
      retry_r     <= '0;
      halt_r      <= HALT_RUNNING;
      run_pend_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_data;
          CFG_RETRY:   limit_r   <= cfg_data[7:0];
          default:     ;
        endcase
      end
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      base_slot_r <= base_slot_nxt;
      next_slot_r <= next_slot_nxt;
      end_r       <= end_nxt;
      active_r    <= active_nxt;
      elapsed_r   <= elapsed_nxt;
      retry_r     <= retry_nxt;
      halt_r      <= halt_nxt;
      run_pend_r  <= run_pend_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gbn_sw_back.sv
// Back end: slot length memory, retransmit sequencer and result register.
`default_nettype none

module gbn_sw_back
  import gbn_sw_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire slot_wr_t slot_wr,
  input  wire logic     q_empty,
  input  wire job_t     q_job,
  output logic          pop,
  output logic          run_done,
  output logic          out_strobe,
  output out_item_t     out_item
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } bk_state_t;

  bk_state_t state_r;

  logic [10:0]   slot_mem [WINDOW];
  logic [10:0]   rd_data_r;

  logic [31:0]   run_seq_r;
  logic [IW-1:0] run_slot_r;
  logic [CW-1:0] run_left_r;

  // Result stage
  logic          st_valid_r;
  action_t       st_action_r;
  logic [31:0]   st_seq_r;
  logic [10:0]   st_len_r;
  logic          st_mem_r;
  logic          st_last_r;

  assign pop      = !q_empty && (state_r == BK_IDLE);
  assign run_done = (state_r == BK_RUN) && (run_left_r == CW'(1));

  assign out_strobe           = st_valid_r;
  assign out_item.action      = st_action_r;
  assign out_item.seq_number  = st_seq_r;
  assign out_item.send_length = st_mem_r ? rd_data_r : st_len_r;
  assign out_item.last_of_run = st_last_r;

  // Slot length memory: front writes, run reads
  always_ff @(posedge clk) begin
    if (slot_wr.en) begin
      slot_mem[slot_wr.addr[IW-1:0]] <= slot_wr.data;
    end
    if (state_r == BK_RUN) begin
      rd_data_r <= slot_mem[run_slot_r];
    end
  end

  // Job sequencer and result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= 1'b0;
      unique case (state_r)
        BK_IDLE: begin
          if (pop) begin
            if (q_job.is_run) begin
              state_r    <= BK_RUN;
              run_seq_r  <= q_job.seq;
              run_slot_r <= q_job.slot[IW-1:0];
              run_left_r <= q_job.count[CW-1:0];
            end else begin
              st_valid_r  <= 1'b1;
              st_action_r <= q_job.action;
              st_seq_r    <= q_job.seq;
              st_len_r    <= q_job.len;
              st_mem_r    <= 1'b0;
              st_last_r   <= 1'b1;
            end
          end
        end
        BK_RUN: begin
          // one retransmit per cycle, oldest first
          st_valid_r  <= 1'b1;
          st_action_r <= ACT_SEND;
          st_seq_r    <= run_seq_r;
          st_len_r    <= '0;
          st_mem_r    <= 1'b1;
          st_last_r   <= (run_left_r == CW'(1));
          run_seq_r   <= run_seq_r + 32'd1;
          run_slot_r  <= (run_slot_r == IW'(WINDOW-1)) ? '0 : run_slot_r + 1'b1;
          run_left_r  <= run_left_r - 1'b1;
          if (run_left_r == CW'(1)) begin
            state_r <= BK_IDLE;
          end
        end
        default: begin
          state_r <= BK_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/go_back_n_sender_window_unit.sv
// Go-back-n sender window unit: top level joining front end, job queue and back end.
// Each item's job is held in the job queue, then its result in the back-end result stage.
// Offers, acknowledgements, ticks and aborts are taken one per cycle while busy is low.
// A timeout resending N outstanding packets gives N results, one per cycle, once the back
//   end has started its run; busy stays high until the last slot memory read is issued.
// Reset (rst_n low, synchronous) clears window, timer and halt state and loads
//   timeout 200, retry limit 10; slot lengths are not cleared. Results cannot be stalled.
`default_nettype none

module go_back_n_sender_window_unit
  import gbn_sw_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             in_item,
  output logic                      out_strobe,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  job_t     push_job, pop_job;
  logic     push, pop;
  logic     q_full, q_empty;
  logic     run_done;
  slot_wr_t slot_wr;

  // Registers always take a write
  assign cfg_ready = 1'b1;

  gbn_sw_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full),
    .run_done  (run_done),
    .slot_wr   (slot_wr)
  );

  gbn_sw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  gbn_sw_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_wr    (slot_wr),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .pop        (pop),
    .run_done   (run_done),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
